>>> rtl/patq_pkg.sv
// Shared constants for the parent array tree query block.
// No dependencies; every other file uses this package.
package patq_pkg;

    localparam int DEF_MAX_NODES = 64;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_CYCLE = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

>>> rtl/patq_if.sv
// Request and response channel interfaces (valid/ready, one beat per item).
// Depends on patq_pkg for the default table size.
interface patq_req_if #(
    parameter int MAX_NODES = patq_pkg::DEF_MAX_NODES
);
    localparam int NODE_W = $clog2(MAX_NODES);

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
    logic signed [NODE_W:0]   parent_value;

    modport source (
        output valid, req_type, node_a, node_b, parent_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_a, node_b, parent_value,
        output ready
    );
endinterface

interface patq_rsp_if #(
    parameter int MAX_NODES = patq_pkg::DEF_MAX_NODES
);
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [NODE_W:0]   parent_of_a;
    logic [CNT_W-1:0]         level_of_a;
    logic [CNT_W-1:0]         children_of_a;
    logic [NODE_W-1:0]        common_ancestor;

    modport source (
        output valid, status, parent_of_a, level_of_a, children_of_a, common_ancestor,
        input  ready
    );
    modport sink (
        input  valid, status, parent_of_a, level_of_a, children_of_a, common_ancestor,
        output ready
    );
endinterface

>>> rtl/patq_table.sv
// Parent table: single-port synchronous RAM with registered read.
// Runs a clearing pass to "no parent" after reset. Depends on patq_pkg.
module patq_table #(
    parameter int MAX_NODES = patq_pkg::DEF_MAX_NODES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [$clog2(MAX_NODES)-1:0]   addr,
    input  logic [$clog2(MAX_NODES):0]     wdata,
    output logic [$clog2(MAX_NODES):0]     rdata,
    output logic                           busy
);
    import patq_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int PAR_W  = NODE_W + 1;

    logic [PAR_W-1:0]  table_mem [MAX_NODES];
    logic [PAR_W-1:0]  rdata_reg;
    logic [NODE_W-1:0] clr_reg;
    logic [NODE_W-1:0] clr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              mem_we;
    logic [NODE_W-1:0] mem_addr;
    logic [PAR_W-1:0]  mem_wdata;

    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == NODE_W'(MAX_NODES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign mem_we    = busy_reg | we;
    assign mem_addr  = busy_reg ? clr_reg : addr;
    assign mem_wdata = busy_reg ? {PAR_W{1'b1}} : wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= table_mem[mem_addr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

>>> rtl/parent_array_tree_query.sv
// Parent array forest with parent, level, child count and common ancestor queries.
// A query beat runs a child scan, two chain walks, then a lift and a paired walk,
// all bound by the single table port. One item in flight; the result register
// lets the next item enter while a response beat waits. After reset the table
// runs a clearing pass, during which no request beat is taken.
module parent_array_tree_query #(
    parameter int MAX_NODES = patq_pkg::DEF_MAX_NODES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [$clog2(MAX_NODES+1)-1:0]     cfg_wdata,
    patq_req_if.sink                           req,
    patq_rsp_if.source                         rsp
);
    import patq_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int PAR_W  = NODE_W + 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHILD  = 9'b000000010,
        ST_WALK   = 9'b000000100,
        ST_ALIGN  = 9'b000001000,
        ST_LIFT   = 9'b000010000,
        ST_PAIR   = 9'b000100000,
        ST_PAIR_A = 9'b001000000,
        ST_PAIR_B = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              err_rng_reg, err_rng_next;
    logic              err_cyc_reg, err_cyc_next;
    logic              chk_reg, chk_next;
    logic              walk_a_reg, walk_a_next;
    logic              lift_a_reg, lift_a_next;

    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [NODE_W-1:0] chk_addr_reg, chk_addr_next;
    logic [CNT_W-1:0]  children_reg, children_next;
    logic [PAR_W-1:0]  pa_reg, pa_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  level_reg, level_next;
    logic [CNT_W-1:0]  depth_b_reg, depth_b_next;
    logic [NODE_W-1:0] xa_reg, xa_next;
    logic [NODE_W-1:0] xb_reg, xb_next;
    logic [CNT_W-1:0]  da_reg, da_next;
    logic [CNT_W-1:0]  db_reg, db_next;
    logic [NODE_W-1:0] lca_reg, lca_next;

    logic [1:0]        rsp_status_reg, rsp_status_next;
    logic [PAR_W-1:0]  rsp_pa_reg, rsp_pa_next;
    logic [CNT_W-1:0]  rsp_level_reg, rsp_level_next;
    logic [CNT_W-1:0]  rsp_children_reg, rsp_children_next;
    logic [NODE_W-1:0] rsp_lca_reg, rsp_lca_next;

    logic              mem_we;
    logic [NODE_W-1:0] mem_addr;
    logic [PAR_W-1:0]  mem_wdata;
    logic [PAR_W-1:0]  mem_rdata;
    logic              clr_busy;

    logic [CNT_W-1:0]  n_eff;
    logic              rd_nop;
    logic [NODE_W-1:0] rd_idx;
    logic              rd_oor;
    logic              req_fire;
    logic              a_oor;
    logic              b_oor;
    logic [1:0]        status_fin;

    patq_table #(
        .MAX_NODES (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (clr_busy)
    );

    assign n_eff = (count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : count_reg;

    assign rd_nop = mem_rdata[NODE_W];
    assign rd_idx = mem_rdata[NODE_W-1:0];
    assign rd_oor = CNT_W'(rd_idx) >= n_eff;

    assign req.ready = (state_reg == ST_IDLE) && !clr_busy;
    assign req_fire  = req.valid && req.ready;
    assign a_oor     = CNT_W'(req.node_a) >= n_eff;
    assign b_oor     = CNT_W'(req.node_b) >= n_eff;

    assign status_fin = err_rng_reg ? STATUS_RANGE :
                        err_cyc_reg ? STATUS_CYCLE : STATUS_OK;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        root_next         = root_reg;
        rsp_valid_next    = rsp_valid_reg;
        err_rng_next      = err_rng_reg;
        err_cyc_next      = err_cyc_reg;
        chk_next          = chk_reg;
        walk_a_next       = walk_a_reg;
        lift_a_next       = lift_a_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        scan_next         = scan_reg;
        chk_addr_next     = chk_addr_reg;
        children_next     = children_reg;
        pa_next           = pa_reg;
        cnt_next          = cnt_reg;
        level_next        = level_reg;
        depth_b_next      = depth_b_reg;
        xa_next           = xa_reg;
        xb_next           = xb_reg;
        da_next           = da_reg;
        db_next           = db_reg;
        lca_next          = lca_reg;
        rsp_status_next   = rsp_status_reg;
        rsp_pa_next       = rsp_pa_reg;
        rsp_level_next    = rsp_level_reg;
        rsp_children_next = rsp_children_reg;
        rsp_lca_next      = rsp_lca_reg;
        mem_we            = 1'b0;
        mem_addr          = a_reg;
        mem_wdata         = req.parent_value[NODE_W] ? {PAR_W{1'b1}} : req.parent_value;

        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_addr = req.node_a;
                if (req_fire)
                begin
                    if (req.req_type == REQ_WRITE)
                    begin
                        if (!a_oor)
                        begin
                            mem_we = 1'b1;
                            if (req.parent_value[NODE_W])
                            begin
                                root_next = req.node_a;
                            end
                        end
                    end
                    else
                    begin
                        a_next        = req.node_a;
                        b_next        = req.node_b;
                        scan_next     = '0;
                        chk_next      = 1'b0;
                        children_next = '0;
                        pa_next       = '0;
                        lca_next      = '0;
                        level_next    = '0;
                        err_rng_next  = a_oor || b_oor;
                        err_cyc_next  = 1'b0;
                        state_next    = (a_oor || b_oor) ? ST_DONE : ST_CHILD;
                    end
                end
            end

            ST_CHILD:
            begin
                if (chk_reg)
                begin
                    if (mem_rdata == {1'b0, a_reg})
                    begin
                        children_next = children_reg + 1'b1;
                    end
                    if (chk_addr_reg == a_reg)
                    begin
                        pa_next = mem_rdata;
                    end
                end
                chk_next      = (scan_reg != n_eff);
                chk_addr_next = scan_reg[NODE_W-1:0];
                if (scan_reg != n_eff)
                begin
                    mem_addr  = scan_reg[NODE_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    mem_addr    = b_reg;
                    cnt_next    = CNT_W'(1);
                    walk_a_next = 1'b0;
                    state_next  = ST_WALK;
                end
            end

            ST_WALK:
            begin
                mem_addr = rd_idx;
                if (rd_nop || rd_oor || (cnt_reg == n_eff))
                begin
                    if (!rd_nop)
                    begin
                        if (rd_oor)
                        begin
                            err_rng_next = 1'b1;
                        end
                        else
                        begin
                            err_cyc_next = 1'b1;
                        end
                    end
                    if (walk_a_reg)
                    begin
                        level_next = cnt_reg;
                        xa_next    = a_reg;
                        xb_next    = b_reg;
                        da_next    = cnt_reg;
                        db_next    = depth_b_reg;
                        if (rd_nop && !err_rng_reg && !err_cyc_reg)
                        begin
                            state_next = ST_ALIGN;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        depth_b_next = cnt_reg;
                        mem_addr     = a_reg;
                        cnt_next     = CNT_W'(1);
                        walk_a_next  = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_ALIGN:
            begin
                if (da_reg > db_reg)
                begin
                    mem_addr    = xa_reg;
                    lift_a_next = 1'b1;
                    state_next  = ST_LIFT;
                end
                else if (db_reg > da_reg)
                begin
                    mem_addr    = xb_reg;
                    lift_a_next = 1'b0;
                    state_next  = ST_LIFT;
                end
                else
                begin
                    state_next = ST_PAIR;
                end
            end

            ST_LIFT:
            begin
                if (lift_a_reg)
                begin
                    xa_next = rd_idx;
                    da_next = da_reg - 1'b1;
                end
                else
                begin
                    xb_next = rd_idx;
                    db_next = db_reg - 1'b1;
                end
                state_next = ST_ALIGN;
            end

            ST_PAIR:
            begin
                mem_addr = xa_reg;
                if (xa_reg == xb_reg)
                begin
                    lca_next   = xa_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PAIR_A;
                end
            end

            ST_PAIR_A:
            begin
                mem_addr = xb_reg;
                if (rd_nop)
                begin
                    lca_next   = root_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    xa_next    = rd_idx;
                    state_next = ST_PAIR_B;
                end
            end

            ST_PAIR_B:
            begin
                xb_next    = rd_idx;
                state_next = ST_PAIR;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_status_next   = status_fin;
                    rsp_pa_next       = pa_reg;
                    rsp_children_next = children_reg;
                    rsp_level_next    = (status_fin == STATUS_OK) ? level_reg : '0;
                    rsp_lca_next      = (status_fin == STATUS_OK) ? lca_reg : '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(MAX_NODES);
            root_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            err_rng_reg   <= 1'b0;
            err_cyc_reg   <= 1'b0;
            chk_reg       <= 1'b0;
            walk_a_reg    <= 1'b0;
            lift_a_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            root_reg      <= root_next;
            rsp_valid_reg <= rsp_valid_next;
            err_rng_reg   <= err_rng_next;
            err_cyc_reg   <= err_cyc_next;
            chk_reg       <= chk_next;
            walk_a_reg    <= walk_a_next;
            lift_a_reg    <= lift_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        b_reg            <= b_next;
        scan_reg         <= scan_next;
        chk_addr_reg     <= chk_addr_next;
        children_reg     <= children_next;
        pa_reg           <= pa_next;
        cnt_reg          <= cnt_next;
        level_reg        <= level_next;
        depth_b_reg      <= depth_b_next;
        xa_reg           <= xa_next;
        xb_reg           <= xb_next;
        da_reg           <= da_next;
        db_reg           <= db_next;
        lca_reg          <= lca_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_pa_reg       <= rsp_pa_next;
        rsp_level_reg    <= rsp_level_next;
        rsp_children_reg <= rsp_children_next;
        rsp_lca_reg      <= rsp_lca_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.parent_of_a     = rsp_pa_reg;
    assign rsp.level_of_a      = rsp_level_reg;
    assign rsp.children_of_a   = rsp_children_reg;
    assign rsp.common_ancestor = rsp_lca_reg;

endmodule
